>>> rtl/core/ecp_pkg.sv
`timescale 1ns / 1ps
package ecp_pkg;

    localparam int KIND_COUNT = 10;
    localparam int MECH_COUNT = 9;
    localparam int KW_BYTES   = 19;
    localparam int MECH_BYTES = 16;

    localparam logic [3:0] KIND_UNKNOWN = 4'd0;
    localparam logic [3:0] KIND_SIZE    = 4'd2;
    localparam logic [3:0] KIND_AUTH    = 4'd3;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [4:0] KW_LEN_MAX = 5'd31;
    localparam logic [3:0] TOK_POS_MAX = 4'd15;

    // keyword text, first character in the lowest byte
    localparam logic [0:KIND_COUNT-1][8*KW_BYTES-1:0] KW_TEXT = '{
        "NSD", "EZIS", "HTUA", "SLTTRATS", "EMIMTIB8", "GNIKNUHC", "8FTUPTMS",
        "GNINILEPIP", "EMIMYRANIB", "SEDOCSUTATSDECNAHNE"
    };
    localparam logic [0:KIND_COUNT-1][4:0] KW_LEN = '{
        5'd3, 5'd4, 5'd4, 5'd8, 5'd8, 5'd8, 5'd8, 5'd10, 5'd10, 5'd19
    };

    localparam logic [0:MECH_COUNT-1][8*MECH_BYTES-1:0] MECH_TEXT = '{
        "NIALP", "NIGOL", "5DM-MARC", "5DM-TSEGID", "2HTUAOX",
        "1-AHS-MARCS", "652-AHS-MARCS", "MLTN", "IPASSG"
    };
    localparam logic [0:MECH_COUNT-1][3:0] MECH_LEN = '{
        4'd5, 4'd5, 4'd8, 4'd10, 4'd7, 4'd11, 4'd13, 4'd4, 4'd6
    };

    typedef struct packed {
        logic clr_all;
        logic clr_line;
        logic step;
        logic commit;
    } t_strb;

    typedef struct packed {
        logic       in_params;
        logic [3:0] cur_kind;
        logic [3:0] kind_eff;
    } t_kw_stat;

    function automatic logic [7:0] fold(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
            r = c - 8'd32;
        end
        return r;
    endfunction

    function automatic logic [3:0] kw_classify(input logic [4:0] len,
                                               input logic [8*KW_BYTES-1:0] kw);
        logic [3:0] r;
        r = KIND_UNKNOWN;
        for (int k = KIND_COUNT - 1; k >= 0; k--) begin
            if (len == KW_LEN[k] && kw == KW_TEXT[k]) begin
                r = 4'(k + 1);
            end
        end
        return r;
    endfunction

    // close an AUTH token: lowest surviving mechanism of matching length, else unknown; an empty token sets no bit
    function automatic logic [9:0] tok_finish(input logic [8:0] cand, input logic [3:0] pos);
        logic [9:0] r;
        logic       hit;
        r   = '0;
        hit = 1'b0;
        for (int k = MECH_COUNT - 1; k >= 0; k--) begin
            if (cand[k] && MECH_LEN[k] == pos) begin
                r   = '0;
                r[k] = 1'b1;
                hit = 1'b1;
            end
        end
        if (pos == 4'd0) begin
            r = '0;
        end else if (!hit) begin
            r[9] = 1'b1;
        end
        return r;
    endfunction

endpackage

>>> rtl/core/ecp_keyword.sv
`timescale 1ns / 1ps
module ecp_keyword import ecp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_strb      i_strb,
    input  logic [7:0] i_byte,
    output t_kw_stat   o_stat
);

    logic [63:0]     r_f8, n_f8;
    logic [10:0][7:0] r_tail, n_tail;
    logic [4:0]      r_len, n_len;
    logic            r_inp, n_inp;
    logic [3:0]      r_kind, n_kind;
    logic [3:0]      kind_cls;
    logic [7:0]      cf;
    logic [4:0]      tail_off;

    assign cf       = fold(i_byte);
    assign tail_off = r_len - 5'd8;

    always_comb begin
        n_f8   = r_f8;
        n_tail = r_tail;
        n_len  = r_len;
        if (!r_inp && i_byte != CH_SPACE) begin
            if (r_len < 5'd8) begin
                n_f8[{r_len[2:0], 3'b000} +: 8] = cf;
            end else if (r_len < 5'd19) begin
                n_tail[tail_off[3:0]] = cf;
            end
            if (r_len < KW_LEN_MAX) begin
                n_len = r_len + 5'd1;
            end
        end
    end

    assign kind_cls = kw_classify(n_len, {n_tail, n_f8});

    always_comb begin
        n_inp  = r_inp;
        n_kind = r_kind;
        if (!r_inp && i_byte == CH_SPACE) begin
            n_inp  = 1'b1;
            n_kind = kind_cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_strb.clr_all || i_strb.clr_line) begin
            r_f8   <= '0;
            r_tail <= '0;
            r_len  <= '0;
            r_inp  <= 1'b0;
            r_kind <= KIND_UNKNOWN;
        end else if (i_strb.step) begin
            r_f8   <= n_f8;
            r_tail <= n_tail;
            r_len  <= n_len;
            r_inp  <= n_inp;
            r_kind <= n_kind;
        end
    end

    assign o_stat.in_params = r_inp;
    assign o_stat.cur_kind  = r_kind;
    assign o_stat.kind_eff  = r_inp ? r_kind : kind_cls;

endmodule

>>> rtl/core/ecp_size.sv
`timescale 1ns / 1ps
module ecp_size import ecp_pkg::*; #(
    parameter int SIZE_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_strb                i_strb,
    input  logic [7:0]           i_byte,
    output logic [SIZE_BITS-1:0] o_limit_next,
    output logic                 o_ok_next
);

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_DIGITS = 2'd1,
        PH_DONE   = 2'd2,
        PH_BAD    = 2'd3
    } t_phase;

    t_phase               r_phase, a_phase;
    logic [SIZE_BITS-1:0] r_acc, a_acc;
    logic [SIZE_BITS-1:0] r_limit, n_limit;
    logic                 r_ok, n_ok;
    logic                 digit;
    logic [3:0]           d;
    logic [SIZE_BITS+3:0] prod;

    assign digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign d     = 4'(i_byte - CH_ZERO);
    // acc * 10 + d, overflow shows in the top four bits
    assign prod  = ({4'd0, r_acc} << 3) + ({4'd0, r_acc} << 1) + (SIZE_BITS+4)'(d);

    always_comb begin
        a_phase = r_phase;
        a_acc   = r_acc;
        if (i_strb.step) begin
            case (r_phase)
                PH_SKIP: begin
                    if (i_byte != CH_SPACE) begin
                        if (digit) begin
                            a_acc   = SIZE_BITS'(d);
                            a_phase = PH_DIGITS;
                        end else begin
                            a_phase = PH_BAD;
                        end
                    end
                end
                PH_DIGITS: begin
                    if (!digit) begin
                        a_phase = PH_DONE;
                    end else if (prod[SIZE_BITS+3:SIZE_BITS] != 4'd0) begin
                        a_phase = PH_BAD;
                    end else begin
                        a_acc = prod[SIZE_BITS-1:0];
                    end
                end
                default: begin
                    a_phase = r_phase;
                end
            endcase
        end
    end

    always_comb begin
        n_limit = r_limit;
        n_ok    = r_ok;
        if (i_strb.commit) begin
            if (a_phase == PH_DIGITS || a_phase == PH_DONE) begin
                n_limit = a_acc;
                n_ok    = 1'b1;
            end else begin
                n_ok = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_strb.clr_all) begin
            r_phase <= PH_SKIP;
            r_acc   <= '0;
            r_limit <= '0;
            r_ok    <= 1'b0;
        end else if (i_strb.clr_line) begin
            r_phase <= PH_SKIP;
            r_acc   <= '0;
            r_limit <= n_limit;
            r_ok    <= n_ok;
        end else begin
            r_phase <= a_phase;
            r_acc   <= a_acc;
        end
    end

    assign o_limit_next = n_limit;
    assign o_ok_next    = n_ok;

endmodule

>>> rtl/core/ecp_auth.sv
`timescale 1ns / 1ps
module ecp_auth import ecp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_strb      i_strb,
    input  logic [7:0] i_byte,
    output logic [9:0] o_mask_next
);

    logic [8:0] r_cand, a_cand;
    logic [3:0] r_pos, a_pos;
    logic [9:0] r_mask, a_mask, n_mask;
    logic [7:0] cf;

    assign cf = fold(i_byte);

    always_comb begin
        a_cand = r_cand;
        a_pos  = r_pos;
        a_mask = r_mask;
        if (i_strb.step) begin
            if (i_byte == CH_SPACE) begin
                a_mask = r_mask | tok_finish(r_cand, r_pos);
                a_cand = '1;
                a_pos  = '0;
            end else begin
                for (int k = 0; k < MECH_COUNT; k++) begin
                    if (r_pos >= MECH_LEN[k] || MECH_TEXT[k][{r_pos, 3'b000} +: 8] != cf) begin
                        a_cand[k] = 1'b0;
                    end
                end
                if (r_pos < TOK_POS_MAX) begin
                    a_pos = r_pos + 4'd1;
                end
            end
        end
    end

    assign n_mask = i_strb.commit ? (a_mask | tok_finish(a_cand, a_pos)) : a_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_strb.clr_all) begin
            r_cand <= '1;
            r_pos  <= '0;
            r_mask <= '0;
        end else if (i_strb.clr_line) begin
            r_cand <= '1;
            r_pos  <= '0;
            r_mask <= n_mask;
        end else begin
            r_cand <= a_cand;
            r_pos  <= a_pos;
            r_mask <= a_mask;
        end
    end

    assign o_mask_next = n_mask;

endmodule

>>> rtl/core/ehlo_capability_line_parser.sv
`timescale 1ns / 1ps
// EHLO capability line parser.
// Input stream: one line byte per beat. s_axis_tdata carries the byte,
// s_axis_tlast marks the last byte of a line, s_axis_tuser high clears all
// capability state (the byte is then ignored and no result follows).
// Output stream: one beat per completed line, carrying the line's kind on
// m_axis_tuser and the accumulated capability summary on m_axis_tdata.
// Each byte is handled in the cycle it is accepted; the result for a line is
// presented from the output register in the cycle after its last byte is accepted.
// Throughput is one byte per cycle while s_axis_tready is high; the keyword fold,
// classify and SIZE multiply-by-ten update are all combinational.
// s_axis_tready drops only while a result sits in the output register and
// m_axis_tready is low; the parser then holds all state until the beat moves.
// Synchronous reset (i_rst_n low) clears every flag, counter and line state
// and empties the output register.
module ehlo_capability_line_parser import ecp_pkg::*; #(
    parameter int MAX_UNKNOWN = 8,
    parameter int SIZE_BITS   = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // data_byte
    input  logic [0:0]  s_axis_tuser,  // func
    input  logic        s_axis_tlast,  // line_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // capability_flags[9:0], size_value[41:10], size_valid[42],
    // auth_mechanisms[52:43], unknown_lines[56:53], unknown_overflow[64:57]
    output logic [71:0] m_axis_tdata,
    output logic [3:0]  m_axis_tuser   // line_kind
);

    localparam int UW = $clog2(MAX_UNKNOWN + 1);

    logic                 acc, byte_acc, line_acc;
    t_strb                kw_strb, sz_strb, au_strb;
    t_kw_stat             kw_stat;
    logic [SIZE_BITS-1:0] limit_next;
    logic                 ok_next;
    logic [9:0]           mask_next;
    logic [9:0]           r_flags, n_flags;
    logic [UW-1:0]        r_unk, n_unk;
    logic [7:0]           r_ovf, n_ovf;
    logic                 r_m_valid;
    logic [71:0]          r_m_data;
    logic [3:0]           r_m_kind;
    logic [63:0]          limit_ext;
    logic [UW+3:0]        unk_ext;

    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign byte_acc      = acc && !s_axis_tuser[0];
    assign line_acc      = byte_acc && s_axis_tlast;

    assign kw_strb = '{clr_all: acc && s_axis_tuser[0], clr_line: line_acc,
                       step: byte_acc, commit: 1'b0};
    assign sz_strb = '{clr_all: acc && s_axis_tuser[0], clr_line: line_acc,
                       step: byte_acc && kw_stat.in_params && kw_stat.cur_kind == KIND_SIZE,
                       commit: line_acc && kw_stat.kind_eff == KIND_SIZE};
    assign au_strb = '{clr_all: acc && s_axis_tuser[0], clr_line: line_acc,
                       step: byte_acc && kw_stat.in_params && kw_stat.cur_kind == KIND_AUTH,
                       commit: line_acc && kw_stat.kind_eff == KIND_AUTH};

    ecp_keyword u_kw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_strb  (kw_strb),
        .i_byte  (s_axis_tdata),
        .o_stat  (kw_stat)
    );

    ecp_size #(.SIZE_BITS(SIZE_BITS)) u_size (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_strb       (sz_strb),
        .i_byte       (s_axis_tdata),
        .o_limit_next (limit_next),
        .o_ok_next    (ok_next)
    );

    ecp_auth u_auth (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_strb      (au_strb),
        .i_byte      (s_axis_tdata),
        .o_mask_next (mask_next)
    );

    always_comb begin
        n_flags = r_flags;
        n_unk   = r_unk;
        n_ovf   = r_ovf;
        if (kw_stat.kind_eff != KIND_UNKNOWN) begin
            for (int k = 1; k <= KIND_COUNT; k++) begin
                if (kw_stat.kind_eff == 4'(k)) begin
                    n_flags[k-1] = 1'b1;
                end
            end
        end else if (r_unk >= UW'(MAX_UNKNOWN)) begin
            if (r_ovf != 8'hFF) begin
                n_ovf = r_ovf + 8'd1;
            end
        end else begin
            n_unk = r_unk + UW'(1);
        end
    end

    assign limit_ext = 64'(limit_next);
    assign unk_ext   = (UW+4)'(n_unk);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (acc && s_axis_tuser[0])) begin
            r_flags <= '0;
            r_unk   <= '0;
            r_ovf   <= '0;
        end else if (line_acc) begin
            r_flags <= n_flags;
            r_unk   <= n_unk;
            r_ovf   <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (line_acc) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    // payload register, loaded only when a line completes
    always_ff @(posedge i_clk) begin
        if (line_acc) begin
            r_m_kind <= kw_stat.kind_eff;
            r_m_data <= {7'd0, n_ovf, unk_ext[3:0], mask_next, ok_next,
                         limit_ext[31:0], n_flags};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_kind;

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import ecp_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // data_byte
    logic [0:0]  s_axis_tuser;   // func
    logic        s_axis_tlast;   // line_end
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // capability_flags, size_value, size_valid, auth_mechanisms, unknown_lines,
    // unknown_overflow
    logic [71:0] m_axis_tdata;
    logic [3:0]  m_axis_tuser;   // line_kind

    localparam logic [0:0] FN_BYTE  = 1'b0;
    localparam logic [0:0] FN_CLEAR = 1'b1;
    localparam int UNK_CAP = 8;
    localparam int RX_HOLD_LEN = 300;

    typedef struct packed {
        logic [3:0]  kind;
        logic [71:0] summary;
    } t_line_res;

    typedef struct {
        logic [0:0] fn;
        logic [7:0] ch;
        logic       eol;
        logic       has_exp;
        logic [3:0] exp_kind;
    } t_row;

    ehlo_capability_line_parser uut (.*);

    // predictor state
    logic        pr_in_params;
    logic [7:0]  pr_kw [0:18];
    logic [4:0]  pr_kw_len;
    logic [3:0]  pr_kind;
    logic [1:0]  pr_size_phase;
    logic [32:0] pr_size_acc;
    logic [8:0]  pr_cand;
    logic [3:0]  pr_tok_pos;
    logic [9:0]  pr_flags;
    logic [31:0] pr_size_lim;
    logic        pr_size_ok;
    logic [9:0]  pr_auth;
    logic [3:0]  pr_unk;
    logic [7:0]  pr_ovf;

    t_line_res   line_results_due[$];
    int          mismatches;
    logic        rx_free_run;
    logic        rx_hold_req;
    int          rx_hold_cycles;
    logic        tx_bursty;

    string kw_names [10] = '{"DSN", "SIZE", "AUTH", "STARTTLS", "8BITMIME", "CHUNKING",
        "SMTPUTF8", "PIPELINING", "BINARYMIME", "ENHANCEDSTATUSCODES"};
    string mech_names [9] = '{"PLAIN", "LOGIN", "CRAM-MD5", "DIGEST-MD5", "XOAUTH2",
        "SCRAM-SHA-1", "SCRAM-SHA-256", "NTLM", "GSSAPI"};

    function automatic logic [7:0] upcase(input logic [7:0] c);
        return (c >= "a" && c <= "z") ? c - 8'd32 : c;
    endfunction

    function automatic logic [3:0] keyword_kind();
        logic [3:0] r;
        logic ok;
        r = KIND_UNKNOWN;
        for (int k = 0; k < 10; k++) begin
            if (r == KIND_UNKNOWN && pr_kw_len == kw_names[k].len()) begin
                ok = 1'b1;
                for (int i = 0; i < kw_names[k].len(); i++)
                    if (pr_kw[i] != kw_names[k][i]) ok = 1'b0;
                if (ok) r = 4'(k + 1);
            end
        end
        return r;
    endfunction

    task automatic clear_line_state();
        pr_in_params = 0;
        for (int i = 0; i < 19; i++) pr_kw[i] = 8'h00;
        pr_kw_len = 0;
        pr_kind = KIND_UNKNOWN;
        pr_size_phase = 0;
        pr_size_acc = 0;
        pr_cand = '1;
        pr_tok_pos = 0;
    endtask

    task automatic clear_capabilities();
        clear_line_state();
        pr_flags = 0;
        pr_size_lim = 0;
        pr_size_ok = 0;
        pr_auth = 0;
        pr_unk = 0;
        pr_ovf = 0;
    endtask

    task automatic close_auth_token();
        int hit;
        if (pr_tok_pos == 0) return;
        hit = -1;
        for (int k = 0; k < 9; k++)
            if (hit < 0 && pr_cand[k] && mech_names[k].len() == pr_tok_pos) hit = k;
        if (hit >= 0) pr_auth[hit] = 1'b1;
        else pr_auth[9] = 1'b1;
        pr_cand = '1;
        pr_tok_pos = 0;
    endtask

    // advance the model by one byte; queues a line result when the byte ends a line
    task automatic parse_byte(input logic [0:0] fn, input logic [7:0] ch, input logic eol);
        logic [7:0]  c;
        logic        dig;
        logic [32:0] d;
        t_line_res   r;
        if (fn == FN_CLEAR) begin
            clear_capabilities();
            return;
        end
        c = ch;
        dig = (c >= "0" && c <= "9");
        d = 33'(c - "0");
        if (!pr_in_params) begin
            if (c == CH_SPACE) begin
                pr_in_params = 1;
                pr_kind = keyword_kind();
            end else begin
                if (pr_kw_len < 19) pr_kw[pr_kw_len] = upcase(c);
                if (pr_kw_len < 31) pr_kw_len++;
            end
        end else if (pr_kind == KIND_SIZE) begin
            if (pr_size_phase == 0) begin
                if (c != CH_SPACE) begin
                    if (dig) begin
                        pr_size_acc = d;
                        pr_size_phase = 1;
                    end else pr_size_phase = 3;
                end
            end else if (pr_size_phase == 1) begin
                if (!dig) pr_size_phase = 2;
                else if ({7'd0, pr_size_acc} * 40'd10 + {7'd0, d} > 40'hFFFF_FFFF)
                    pr_size_phase = 3;
                else pr_size_acc = pr_size_acc * 10 + d;
            end
        end else if (pr_kind == KIND_AUTH) begin
            if (c == CH_SPACE) close_auth_token();
            else begin
                c = upcase(c);
                for (int k = 0; k < 9; k++)
                    if (pr_tok_pos >= mech_names[k].len() || mech_names[k][pr_tok_pos] != c)
                        pr_cand[k] = 1'b0;
                if (pr_tok_pos < 15) pr_tok_pos++;
            end
        end
        if (!eol) return;
        if (!pr_in_params) pr_kind = keyword_kind();
        if (pr_kind != KIND_UNKNOWN) begin
            pr_flags[pr_kind - 1] = 1'b1;
            if (pr_kind == KIND_SIZE) begin
                if (pr_size_phase == 1 || pr_size_phase == 2) begin
                    pr_size_lim = pr_size_acc[31:0];
                    pr_size_ok = 1;
                end else pr_size_ok = 0;
            end else if (pr_kind == KIND_AUTH) close_auth_token();
        end else if (pr_unk >= UNK_CAP) begin
            if (pr_ovf != 8'hFF) pr_ovf++;
        end else pr_unk++;
        r.kind = pr_kind;
        r.summary = {7'd0, pr_ovf, pr_unk, pr_auth, pr_size_ok, pr_size_lim, pr_flags};
        line_results_due.push_back(r);
        clear_line_state();
    endtask

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("testbench: FAIL");
        $finish;
    end

    // result checker and receiver stalls
    initial begin
        int gap;
        t_line_res e;
        m_axis_tready = 0;
        mismatches = 0;
        gap = 0;
        rx_hold_cycles = 0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                if (line_results_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result beat kind=%0d", m_axis_tuser);
                end else begin
                    e = line_results_due.pop_front();
                    if (e.kind !== m_axis_tuser || e.summary !== m_axis_tdata) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch kind exp %0d got %0d, summary exp %h got %h",
                                e.kind, m_axis_tuser, e.summary, m_axis_tdata);
                    end
                end
            end
            if (rx_hold_req && rx_hold_cycles < RX_HOLD_LEN) begin
                rx_hold_cycles++;
                m_axis_tready <= 1'b0;
            end else if (rx_free_run || !i_rst_n) m_axis_tready <= i_rst_n;
            else if (gap > 0) begin
                gap--;
                m_axis_tready <= 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 19);
                m_axis_tready <= 1'b0;
            end else m_axis_tready <= 1'b1;
        end
    end

    task automatic send_beat(input logic [0:0] fn, input logic [7:0] ch, input logic eol);
        if (tx_bursty && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= fn;
        s_axis_tdata <= ch;
        s_axis_tlast <= eol;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        parse_byte(fn, ch, eol);
    endtask

    task automatic send_line(input string s);
        for (int i = 0; i < s.len(); i++) send_beat(FN_BYTE, s[i], i == s.len() - 1);
    endtask

    function automatic logic [7:0] rand_case(input logic [7:0] c);
        return (c >= "A" && c <= "Z" && $urandom_range(0, 1)) ? c + 8'd32 : c;
    endfunction

    task automatic send_random_line(output int n_bytes);
        string s;
        int pick;
        int n;
        pick = $urandom_range(0, 9);
        s = "";
        if (pick < 3) begin
            s = "SIZE";
            repeat ($urandom_range(0, 3)) s = {s, " "};
            n = $urandom_range(0, 3);
            if (n == 0) s = {s, $sformatf("%0d", $urandom)};
            else if (n == 1) s = {s, $sformatf("%0d", $urandom_range(0, 999))};
            else if (n == 2) s = {s, "42949672", string'(8'($urandom_range("0", "9"))),
                string'(8'($urandom_range("0", "9")))};
            else s = {s, string'(8'($urandom_range(0, 255)))};
            if ($urandom_range(0, 3) == 0) s = {s, "x1"};
        end else if (pick < 6) begin
            s = "AUTH";
            repeat ($urandom_range(0, 4)) begin
                s = {s, " "};
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 16)) s = {s, string'(8'($urandom_range(33, 126)))};
                else s = {s, mech_names[$urandom_range(0, 8)]};
            end
        end else if (pick < 8) begin
            s = kw_names[$urandom_range(0, 9)];
            if ($urandom_range(0, 2) == 0) s = {s, " x"};
        end else begin
            repeat ($urandom_range(1, 24)) s = {s, string'(8'($urandom_range(0, 255)))};
        end
        for (int i = 0; i < s.len(); i++) s[i] = rand_case(s[i]);
        n_bytes = s.len();
        send_line(s);
    endtask

    t_row dir_rows [$];
    task automatic add_row(input logic [0:0] fn, input logic [7:0] ch, input logic eol,
                           input logic has, input logic [3:0] k);
        t_row r;
        r.fn = fn; r.ch = ch; r.eol = eol; r.has_exp = has; r.exp_kind = k;
        dir_rows.push_back(r);
    endtask

    initial begin
        int n_items;
        int n_bytes;
        t_line_res peek;
        i_rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = 0;
        s_axis_tuser = FN_BYTE;
        s_axis_tlast = 0;
        rx_free_run = 0;
        rx_hold_req = 0;
        tx_bursty = 1;
        clear_capabilities();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: byte extremes, clear, empty keyword, DSN
        add_row(FN_BYTE, 8'h00, 1'b1, 1, KIND_UNKNOWN);
        add_row(FN_BYTE, 8'hFF, 1'b1, 1, KIND_UNKNOWN);
        add_row(FN_BYTE, CH_SPACE, 1'b1, 1, KIND_UNKNOWN);
        add_row(FN_CLEAR, 8'hFF, 1'b1, 0, KIND_UNKNOWN);
        add_row(FN_BYTE, "d", 1'b0, 0, 0);
        add_row(FN_BYTE, "s", 1'b0, 0, 0);
        add_row(FN_BYTE, "N", 1'b1, 1, 4'd1);
        foreach (dir_rows[i]) begin
            send_beat(dir_rows[i].fn, dir_rows[i].ch, dir_rows[i].eol);
            if (dir_rows[i].has_exp) begin
                peek = line_results_due[$];
                if (peek.kind !== dir_rows[i].exp_kind) begin
                    mismatches++;
                    if (mismatches <= 10) $display("directed row %0d kind exp %0d model %0d",
                        i, dir_rows[i].exp_kind, peek.kind);
                end
            end
        end
        send_line("SIZE 4294967295");
        send_line("SIZE 4294967296");
        send_line("SIZE");
        send_line("SIZE  x");
        send_line("AUTH plain Login XOAUTH2 AVERYLONGMECHANISMNAME");
        send_line("enhancedstatuscodes");

        // hold off the receiver so the output stalls the input
        rx_hold_req = 1;
        tx_bursty = 0;
        while (rx_hold_cycles < RX_HOLD_LEN) begin
            if (s_axis_tready) send_line("PIPELINING");
            else @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b0;
        rx_hold_req = 0;
        tx_bursty = 1;
        // sender pauses until every result is back
        while (line_results_due.size() != 0) @(posedge i_clk);

        n_items = 0;
        while (n_items < 1900) begin
            if ($urandom_range(0, 60) == 0) begin
                send_beat(FN_CLEAR, 8'($urandom), 1'($urandom));
                n_items++;
            end else begin
                send_random_line(n_bytes);
                n_items += n_bytes;
            end
            if (n_items > 1600) begin
                tx_bursty = 0;
                rx_free_run = 1;
            end
        end
        s_axis_tvalid <= 1'b0;
        while (line_results_due.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) $display("testbench: PASS");
        else $display("testbench: FAIL");
        $finish;
    end

endmodule

>>> files.f
rtl/core/ecp_pkg.sv
rtl/core/ecp_keyword.sv
rtl/core/ecp_size.sv
rtl/core/ecp_auth.sv
rtl/core/ehlo_capability_line_parser.sv
test/testbench.sv
